### design/trc_pkg.sv
package trc_pkg;

  localparam int RING_DEPTH  = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int RING_W     = 2 * SAMPLE_BITS;
  localparam int CHAN_W     = 16;
  localparam int TIME_W     = 32;
  localparam int OFFSET_W   = 10;
  localparam int POST_W     = 11;
  localparam int CMD_W      = 2;
  localparam int EVENT_W    = 3;
  localparam int PHASE_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int SUM_W      = ((PTR_W > OFFSET_W) ? PTR_W : OFFSET_W) + 1;

  localparam logic signed [CHAN_W-1:0] THRESHOLD_RST = 16'sd16384;
  localparam logic [POST_W-1:0]        POST_RST      = 11'd512;
  localparam logic [TIME_W-1:0]        INTERVAL_RST  = 32'd1000;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE,
    CMD_ARM,
    CMD_READ,
    CMD_RELEASE
  } cmd_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE,
    PH_WATCH,
    PH_POST,
    PH_FROZEN
  } phase_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_STORED,
    EV_LOGGED,
    EV_TRIG,
    EV_DONE,
    EV_READ,
    EV_IGNORED
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD,
    CFG_POST_SAMPLES,
    CFG_LOG_INTERVAL
  } cfg_reg_t;

  typedef logic [PTR_W-1:0]       ptr_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // ring port request from the control stage
  typedef struct packed {
    logic              we;
    ptr_t              waddr;
    logic [RING_W-1:0] wdata;
    logic              re;
    ptr_t              raddr;
  } ring_req_t;

  // result in flight while the ring read completes
  typedef struct packed {
    logic                     valid;
    event_t                   ev;
    logic signed [CHAN_W-1:0] chan0;
    logic signed [CHAN_W-1:0] chan1;
    logic [TIME_W-1:0]        time_ms;
    phase_t                   phase;
    logic                     from_ram;
  } stage_t;

  function automatic sample_t to_sample(input logic [CHAN_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[SAMPLE_BITS-1:0];
  endfunction

  function automatic logic [CHAN_W-1:0] from_sample(input sample_t s);
    logic [31:0] w;
    w = 32'(s);
    return w[CHAN_W-1:0];
  endfunction

  // (pointer + offset) mod RING_DEPTH
  function automatic ptr_t ring_index(input logic [SUM_W-1:0] sum);
    logic [SUM_W-1:0] r;
    logic [63:0]      step;
    r = sum;
    if ((RING_DEPTH & (RING_DEPTH - 1)) != 0) begin
      for (int k = SUM_W - 1; k >= 0; k--) begin
        step = 64'(RING_DEPTH) << k;
        if (step < (64'd1 << SUM_W) && 64'(r) >= step) begin
          r = r - SUM_W'(step);
        end
      end
    end
    return r[PTR_W-1:0];
  endfunction

endpackage

### design/trc_item_if.sv
interface trc_item_if import trc_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           cmd;
  logic signed [CHAN_W-1:0]   chan0;
  logic signed [CHAN_W-1:0]   chan1;
  logic [TIME_W-1:0]          now_ms;
  logic [OFFSET_W-1:0]        read_offset;

  modport source (output valid, cmd, chan0, chan1, now_ms, read_offset, input ready);
  modport sink   (input valid, cmd, chan0, chan1, now_ms, read_offset, output ready);
endinterface

### design/trc_res_if.sv
interface trc_res_if import trc_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [EVENT_W-1:0]         event_res;
  logic signed [CHAN_W-1:0]   out_chan0;
  logic signed [CHAN_W-1:0]   out_chan1;
  logic [TIME_W-1:0]          out_time_ms;
  logic [PHASE_W-1:0]         phase;

  modport source (output valid, event_res, out_chan0, out_chan1, out_time_ms, phase,
                  input ready);
  modport sink   (input valid, event_res, out_chan0, out_chan1, out_time_ms, phase,
                  output ready);
endinterface

### design/trc_cfg_if.sv
interface trc_cfg_if import trc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/trc_ram.sv
module trc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/trc_ctrl.sv
module trc_ctrl import trc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  trc_cfg_if.sink        cfg,
  trc_item_if.sink       item,
  input  logic           s1_take,
  output ring_req_t      ring_req,
  output stage_t         s1
);

  logic signed [CHAN_W-1:0] threshold;
  logic [POST_W-1:0]        post_samples;
  logic [TIME_W-1:0]        log_interval;

  phase_t            phase, phase_next;
  ptr_t              wp, wp_next;
  logic [POST_W-1:0] post_count, count_next;
  logic [TIME_W-1:0] last_log_ms, last_next;

  logic clr_busy;
  ptr_t clr_addr;

  logic              accept, s1_adv;
  cmd_t              cmd;
  sample_t           st0, st1;
  logic signed [SAMPLE_BITS-1:0] st0_s;
  logic signed [32:0] s0w, thw;
  logic              trig, log_due;
  logic [TIME_W-1:0] elapsed;
  ptr_t              wp_inc;
  logic [POST_W-1:0] cnt_inc;
  logic              stores;

  event_t                   ev;
  logic signed [CHAN_W-1:0] o0, o1;
  logic [TIME_W-1:0]        ot;

  assign cfg.ready  = 1'b1;
  assign s1_adv     = !s1.valid || s1_take;
  assign item.ready = !clr_busy && s1_adv;
  assign accept     = item.valid && item.ready;
  assign cmd        = cmd_t'(item.cmd);

  assign st0     = to_sample(item.chan0);
  assign st1     = to_sample(item.chan1);
  assign st0_s   = st0;
  assign s0w     = 33'(st0_s);
  assign thw     = 33'(threshold);
  assign trig    = s0w >= thw;
  assign elapsed = item.now_ms - last_log_ms;
  assign log_due = elapsed >= log_interval;
  assign wp_inc  = (wp == PTR_W'(RING_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign cnt_inc = (post_count != '1) ? post_count + 1'b1 : post_count;
  assign stores  = (cmd == CMD_SAMPLE) && (phase == PH_WATCH || phase == PH_POST);

  // next state
  always_comb begin
    phase_next = phase;
    wp_next    = wp;
    count_next = post_count;
    last_next  = last_log_ms;
    if (accept) begin
      case (cmd)
        CMD_SAMPLE: begin
          if (phase == PH_WATCH) begin
            wp_next = wp_inc;
            if (trig) begin
              phase_next = PH_POST;
              count_next = '0;
              last_next  = item.now_ms;
            end else if (log_due) begin
              last_next = item.now_ms;
            end
          end else if (phase == PH_POST) begin
            wp_next    = wp_inc;
            count_next = cnt_inc;
            if (cnt_inc >= post_samples) begin
              phase_next = PH_FROZEN;
            end
          end
        end
        CMD_ARM: begin
          phase_next = PH_WATCH;
          wp_next    = '0;
          count_next = '0;
          last_next  = item.now_ms;
        end
        CMD_RELEASE: begin
          if (phase == PH_FROZEN) begin
            phase_next = PH_WATCH;
          end
        end
        default: ;
      endcase
    end
  end

  // outputs
  always_comb begin
    ev = EV_IGNORED;
    o0 = '0;
    o1 = '0;
    ot = '0;
    case (cmd)
      CMD_SAMPLE: begin
        if (phase == PH_WATCH) begin
          if (trig) begin
            ev = EV_TRIG;
          end else if (log_due) begin
            ev = EV_LOGGED;
            o0 = item.chan0;
            o1 = item.chan1;
            ot = item.now_ms;
          end else begin
            ev = EV_STORED;
          end
        end else if (phase == PH_POST) begin
          ev = (cnt_inc >= post_samples) ? EV_DONE : EV_STORED;
        end
      end
      CMD_ARM:     ev = EV_STORED;
      CMD_READ:    ev = EV_READ;
      CMD_RELEASE: ev = (phase == PH_FROZEN) ? EV_STORED : EV_IGNORED;
      default:     ev = EV_IGNORED;
    endcase

    ring_req.raddr = ring_index(SUM_W'(wp) + SUM_W'(item.read_offset));
    ring_req.re    = accept && (cmd == CMD_READ);
    if (clr_busy) begin
      ring_req.we    = 1'b1;
      ring_req.waddr = clr_addr;
      ring_req.wdata = '0;
    end else begin
      ring_req.we    = accept && stores;
      ring_req.waddr = wp;
      ring_req.wdata = {st1, st0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RST;
      post_samples <= POST_RST;
      log_interval <= INTERVAL_RST;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        CFG_THRESHOLD:    threshold    <= cfg.data[CHAN_W-1:0];
        CFG_POST_SAMPLES: post_samples <= cfg.data[POST_W-1:0];
        CFG_LOG_INTERVAL: log_interval <= cfg.data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      wp          <= '0;
      post_count  <= '0;
      last_log_ms <= '0;
      clr_busy    <= 1'b1;
      clr_addr    <= '0;
    end else begin
      phase       <= phase_next;
      wp          <= wp_next;
      post_count  <= count_next;
      last_log_ms <= last_next;
      if (clr_busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == PTR_W'(RING_DEPTH - 1)) begin
          clr_busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (s1_adv) begin
      s1.valid    <= accept;
      s1.ev       <= ev;
      s1.chan0    <= o0;
      s1.chan1    <= o1;
      s1.time_ms  <= ot;
      s1.phase    <= phase_next;
      s1.from_ram <= (cmd == CMD_READ);
    end
  end

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1.valid && !s1_take |=> $stable(s1))
    else $error("held result changed under stall");

  a_log_watch: assert property (@(posedge clk) disable iff (rst)
    s1.valid && s1.ev == EV_LOGGED |-> s1.phase == PH_WATCH)
    else $error("log event outside watching phase");

  a_done_frozen: assert property (@(posedge clk) disable iff (rst)
    s1.valid && s1.ev == EV_DONE |-> s1.phase == PH_FROZEN)
    else $error("capture complete without freeze");

  a_read_src: assert property (@(posedge clk) disable iff (rst)
    s1.valid |-> s1.from_ram == (s1.ev == EV_READ))
    else $error("ring data selected for non-read result");

  a_clear_len: assert property (@(posedge clk) disable iff (rst)
    $fell(clr_busy) |-> $past(clr_addr) == PTR_W'(RING_DEPTH - 1))
    else $error("clearing pass ended early");

endmodule

### design/trc_outq.sv
module trc_outq import trc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  stage_t            s1,
  input  logic [RING_W-1:0] ring_rdata,
  output logic              s1_take,
  trc_res_if.source         res
);

  logic                     o_valid;
  event_t                   o_ev;
  logic signed [CHAN_W-1:0] o_chan0, o_chan1;
  logic [TIME_W-1:0]        o_time;
  phase_t                   o_phase;

  logic [CHAN_W-1:0] rd0, rd1;

  assign rd0     = from_sample(ring_rdata[SAMPLE_BITS-1:0]);
  assign rd1     = from_sample(ring_rdata[RING_W-1:SAMPLE_BITS]);
  assign s1_take = !o_valid || res.ready;

  assign res.valid       = o_valid;
  assign res.event_res   = o_ev;
  assign res.out_chan0   = o_chan0;
  assign res.out_chan1   = o_chan1;
  assign res.out_time_ms = o_time;
  assign res.phase       = o_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_take) begin
      o_valid <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && s1.valid) begin
      o_ev    <= s1.ev;
      o_chan0 <= s1.from_ram ? rd0 : s1.chan0;
      o_chan1 <= s1.from_ram ? rd1 : s1.chan1;
      o_time  <= s1.time_ms;
      o_phase <= s1.phase;
    end
  end

endmodule

### design/triggered_ring_capture_unit.sv
// channel  dir  type          transfer carries
// cfg      in   trc_cfg_if    index, data (register write)
// item     in   trc_item_if   cmd, chan0, chan1, now_ms, read_offset
// res      out  trc_res_if    event_res, out_chan0, out_chan1, out_time_ms, phase
//
// One item per cycle while item.ready is high; a result is registered in s1
// alongside the ring read, then in the output register.
// After rst the ring is swept to zero, one entry a cycle over all RING_DEPTH
// (1024) entries; item.ready stays low meanwhile, cfg is always ready.
// A stalled res keeps one result in the output register and one in flight; apart
// from the sweep, item.ready drops only when both are full and res.ready is low.
module triggered_ring_capture_unit import trc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  trc_cfg_if.sink    cfg,
  trc_item_if.sink   item,
  trc_res_if.source  res
);

  ring_req_t         ring_req;
  stage_t            s1;
  logic              s1_take;
  logic [RING_W-1:0] ring_rdata;

  trc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .item     (item),
    .s1_take  (s1_take),
    .ring_req (ring_req),
    .s1       (s1)
  );

  trc_ram #(
    .WIDTH (RING_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_req.we),
    .waddr (ring_req.waddr),
    .wdata (ring_req.wdata),
    .re    (ring_req.re),
    .raddr (ring_req.raddr),
    .rdata (ring_rdata)
  );

  trc_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .s1         (s1),
    .ring_rdata (ring_rdata),
    .s1_take    (s1_take),
    .res        (res)
  );

endmodule

### verif/triggered_ring_capture_unit_tb.sv
`timescale 1ns / 1ps

module triggered_ring_capture_unit_tb;
  import trc_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    cmd_t                     cmd;
    logic signed [CHAN_W-1:0] chan0;
    logic signed [CHAN_W-1:0] chan1;
    logic [TIME_W-1:0]        now_ms;
    logic [OFFSET_W-1:0]      read_offset;
  } capture_item_t;

  typedef struct {
    logic [EVENT_W-1:0]       ev;
    logic signed [CHAN_W-1:0] chan0;
    logic signed [CHAN_W-1:0] chan1;
    logic [TIME_W-1:0]        time_ms;
    logic [PHASE_W-1:0]       phase;
  } capture_result_t;

  class capture_scoreboard;
    logic [RING_W-1:0]        ring [RING_DEPTH];
    ptr_t                     wr_ptr;
    logic [POST_W-1:0]        post_cnt;
    phase_t                   phase;
    logic [TIME_W-1:0]        last_log_ms;
    logic signed [CHAN_W-1:0] threshold;
    logic [POST_W-1:0]        post_target;
    logic [TIME_W-1:0]        log_interval;
    capture_result_t          expected_results [$];
    int                       errors;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_ptr       = '0;
      post_cnt     = '0;
      phase        = PH_IDLE;
      last_log_ms  = '0;
      threshold    = THRESHOLD_RST;
      post_target  = POST_RST;
      log_interval = INTERVAL_RST;
      errors       = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_THRESHOLD:    threshold    = data[CHAN_W-1:0];
        CFG_POST_SAMPLES: post_target  = data[POST_W-1:0];
        CFG_LOG_INTERVAL: log_interval = data[TIME_W-1:0];
        default: ;
      endcase
    endfunction

    function void store_pair(capture_item_t it);
      ring[wr_ptr] = {it.chan0[SAMPLE_BITS-1:0], it.chan1[SAMPLE_BITS-1:0]};
      wr_ptr = ptr_t'((int'(wr_ptr) + 1) % RING_DEPTH);
    endfunction

    // predicts the result of one accepted transfer and queues it
    function event_t note_item(capture_item_t it);
      capture_result_t   r;
      logic [TIME_W-1:0] elapsed;
      ptr_t              idx;
      r.ev      = EV_IGNORED;
      r.chan0   = '0;
      r.chan1   = '0;
      r.time_ms = '0;
      case (it.cmd)
        CMD_SAMPLE: begin
          if (phase == PH_WATCH) begin
            elapsed = it.now_ms - last_log_ms;   // wraps mod 2^32
            store_pair(it);
            if (it.chan0 >= threshold) begin
              phase       = PH_POST;
              post_cnt    = '0;
              last_log_ms = it.now_ms;
              r.ev        = EV_TRIG;
            end else if (elapsed >= log_interval) begin
              last_log_ms = it.now_ms;
              r.ev        = EV_LOGGED;
              r.chan0     = it.chan0;
              r.chan1     = it.chan1;
              r.time_ms   = it.now_ms;
            end else begin
              r.ev = EV_STORED;
            end
          end else if (phase == PH_POST) begin
            store_pair(it);
            if (post_cnt != '1) post_cnt++;
            if (post_cnt >= post_target) begin
              phase = PH_FROZEN;
              r.ev  = EV_DONE;
            end else begin
              r.ev = EV_STORED;
            end
          end
        end
        CMD_ARM: begin
          phase       = PH_WATCH;
          wr_ptr      = '0;
          post_cnt    = '0;
          last_log_ms = it.now_ms;
          r.ev        = EV_STORED;
        end
        CMD_READ: begin
          idx = ptr_t'((int'(wr_ptr) + int'(it.read_offset)) % RING_DEPTH);
          r.chan0 = CHAN_W'(ring[idx][RING_W-1:SAMPLE_BITS]);
          r.chan1 = CHAN_W'(ring[idx][SAMPLE_BITS-1:0]);
          r.ev    = EV_READ;
        end
        CMD_RELEASE: begin
          if (phase == PH_FROZEN) begin
            phase = PH_WATCH;
            r.ev  = EV_STORED;
          end
        end
        default: ;
      endcase
      r.phase = phase;
      expected_results.push_back(r);
      return event_t'(r.ev);
    endfunction

    function void check_result(capture_result_t got);
      capture_result_t want;
      if (expected_results.size() == 0) begin
        $error("result with no transfer pending: event_res %0d", got.ev);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.ev !== want.ev) begin
        $error("event_res: expected %0d, actual %0d", want.ev, got.ev);
        errors++;
      end
      if (got.chan0 !== want.chan0) begin
        $error("out_chan0: expected %0d, actual %0d", want.chan0, got.chan0);
        errors++;
      end
      if (got.chan1 !== want.chan1) begin
        $error("out_chan1: expected %0d, actual %0d", want.chan1, got.chan1);
        errors++;
      end
      if (got.time_ms !== want.time_ms) begin
        $error("out_time_ms: expected %0d, actual %0d", want.time_ms, got.time_ms);
        errors++;
      end
      if (got.phase !== want.phase) begin
        $error("phase: expected %0d, actual %0d", want.phase, got.phase);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  trc_cfg_if  cfg_bus ();
  trc_item_if item_bus ();
  trc_res_if  res_bus ();

  triggered_ring_capture_unit dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_bus),
    .item (item_bus),
    .res  (res_bus)
  );

  capture_scoreboard sb = new();
  bit                quiet;
  logic [TIME_W-1:0] wall_ms;
  int                stall_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < 21);
  endfunction

  // result side: check every transfer, stall at random
  always @(posedge clk) begin
    capture_result_t got;
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        got.ev      = res_bus.event_res;
        got.chan0   = res_bus.out_chan0;
        got.chan1   = res_bus.out_chan1;
        got.time_ms = res_bus.out_time_ms;
        got.phase   = res_bus.phase;
        sb.check_result(got);
      end
      res_bus.ready <= !idle_now();
    end
  end

  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // upper data bits are don't-care for the narrow registers
  task automatic configure(input logic signed [CHAN_W-1:0] th, input logic [POST_W-1:0] ps,
                           input logic [TIME_W-1:0] iv);
    write_reg(CFG_THRESHOLD, {16'($urandom), th});
    write_reg(CFG_POST_SAMPLES, {21'($urandom), ps});
    write_reg(CFG_LOG_INTERVAL, iv);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_item(input capture_item_t it, output event_t ev);
    while (idle_now()) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid       <= 1'b1;
    item_bus.cmd         <= it.cmd;
    item_bus.chan0       <= it.chan0;
    item_bus.chan1       <= it.chan1;
    item_bus.now_ms      <= it.now_ms;
    item_bus.read_offset <= it.read_offset;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    ev = sb.note_item(it);
  endtask

  // wait until every predicted result is back and the pipeline is empty
  task automatic settle();
    item_bus.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic capture_item_t make_item(cmd_t c, int c0, int c1, logic [TIME_W-1:0] t,
                                              int off);
    capture_item_t it;
    it.cmd         = c;
    it.chan0       = CHAN_W'(c0);
    it.chan1       = CHAN_W'(c1);
    it.now_ms      = t;
    it.read_offset = OFFSET_W'(off);
    return it;
  endfunction

  function automatic logic [CHAN_W-1:0] random_chan();
    int p;
    p = $urandom_range(9);
    if (p == 0) return 16'h8000;
    if (p == 1) return 16'h7fff;
    return 16'($urandom);
  endfunction

  // command mix follows the capture phase so most traffic gets past arming
  function automatic capture_item_t random_item();
    capture_item_t it;
    int            p;
    int            th;
    p  = $urandom_range(99);
    th = sb.threshold;
    case (sb.phase)
      PH_IDLE:
        it.cmd = cmd_t'(p < 60 ? CMD_ARM : p < 75 ? CMD_SAMPLE : p < 90 ? CMD_READ : CMD_RELEASE);
      PH_WATCH:
        it.cmd = cmd_t'(p < 85 ? CMD_SAMPLE : p < 90 ? CMD_ARM : p < 97 ? CMD_READ : CMD_RELEASE);
      PH_POST:
        // long captures must be allowed to finish, so arm only when post_target is 64 or less
        it.cmd = cmd_t'(p < 90 ? CMD_SAMPLE : p < 98 ? CMD_READ :
                        (p < 99 || sb.post_target > 64) ? CMD_RELEASE : CMD_ARM);
      default:
        it.cmd = cmd_t'(p < 45 ? CMD_READ : p < 75 ? CMD_RELEASE : p < 85 ? CMD_ARM : CMD_SAMPLE);
    endcase

    it.chan1 = random_chan();
    p = $urandom_range(99);
    if (sb.phase == PH_WATCH && p < 6) begin
      it.chan0 = CHAN_W'(th + int'($urandom_range(0, 32767 - th)));
    end else if (sb.phase == PH_WATCH && p < 80 && th > -32768) begin
      it.chan0 = CHAN_W'(int'($urandom_range(0, th + 32767)) - 32768);
    end else begin
      it.chan0 = random_chan();
    end

    p = $urandom_range(99);
    if (p < 60) wall_ms = wall_ms + $urandom_range(0, 40);
    else if (p < 80) wall_ms = wall_ms + sb.log_interval - 2 + $urandom_range(0, 4);
    else if (p < 95) wall_ms = $urandom;
    it.now_ms = wall_ms;

    p = $urandom_range(9);
    if (p == 0) it.read_offset = '0;
    else if (p == 1) it.read_offset = '1;
    else it.read_offset = OFFSET_W'($urandom);
    return it;
  endfunction

  task automatic run_phase(input logic signed [CHAN_W-1:0] th, input logic [POST_W-1:0] ps,
                           input logic [TIME_W-1:0] iv, input int count);
    int            n;
    event_t        ev;
    capture_item_t it;
    configure(th, ps, iv);
    n = 0;
    while (n < count) begin
      it = random_item();
      send_item(it, ev);
      if (ev != EV_IGNORED) n++;
    end
    settle();
  endtask

  initial begin
    event_t ev;
    rst                  <= 1'b1;
    item_bus.valid       <= 1'b0;
    item_bus.cmd         <= CMD_SAMPLE;
    item_bus.chan0       <= '0;
    item_bus.chan1       <= '0;
    item_bus.now_ms      <= '0;
    item_bus.read_offset <= '0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= CFG_THRESHOLD;
    cfg_bus.data         <= '0;
    quiet        = 1'b0;
    wall_ms      = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    configure(16'sd1000, 11'd3, 32'd10);
    send_item(make_item(CMD_SAMPLE, 32767, 1, 50, 0), ev);        // not armed yet
    send_item(make_item(CMD_RELEASE, 0, 0, 51, 0), ev);
    send_item(make_item(CMD_READ, 0, 0, 52, 0), ev);              // cleared entry
    send_item(make_item(CMD_ARM, 0, 0, 100, 0), ev);
    send_item(make_item(CMD_SAMPLE, -32768, 32767, 105, 0), ev);
    send_item(make_item(CMD_SAMPLE, 999, -1, 110, 0), ev);        // interval just met
    send_item(make_item(CMD_SAMPLE, 0, 16'h1234, 32'hffff_fff0, 0), ev);
    send_item(make_item(CMD_SAMPLE, -1, 0, 4, 0), ev);            // time wrapped
    send_item(make_item(CMD_RELEASE, 0, 0, 4, 0), ev);            // release while watching
    send_item(make_item(CMD_SAMPLE, 1000, -32768, 5, 0), ev);     // exactly at threshold
    send_item(make_item(CMD_READ, 0, 0, 5, 1023), ev);
    send_item(make_item(CMD_SAMPLE, 5, 6, 6, 0), ev);
    send_item(make_item(CMD_SAMPLE, -5, -6, 7, 0), ev);
    send_item(make_item(CMD_SAMPLE, 32767, 32767, 8, 0), ev);     // capture done
    send_item(make_item(CMD_SAMPLE, 1, 1, 9, 0), ev);             // frozen
    send_item(make_item(CMD_READ, 0, 0, 9, 0), ev);
    send_item(make_item(CMD_READ, 0, 0, 9, 1023), ev);
    send_item(make_item(CMD_RELEASE, 0, 0, 10, 0), ev);
    send_item(make_item(CMD_SAMPLE, 32767, 0, 20, 0), ev);
    send_item(make_item(CMD_ARM, 0, 0, 30, 0), ev);               // arm during post-trigger
    send_item(make_item(CMD_READ, 0, 0, 30, 5), ev);
    send_item(make_item(CMD_SAMPLE, -32768, -32768, 31, 0), ev);
    send_item(make_item(CMD_READ, 0, 0, 31, 682), ev);
    settle();

    run_phase(THRESHOLD_RST, POST_RST, INTERVAL_RST, 200);
    run_phase(16'sh8000, 11'd1, 32'd0, 150);                      // every watching sample triggers
    run_phase(16'sh7fff, 11'd0, 32'hffff_ffff, 150);
    quiet = 1'b1;
    run_phase(16'($urandom), 11'($urandom_range(1, 40)), $urandom_range(0, 100), 300);
    quiet = 1'b0;
    run_phase(16'($urandom), 11'd1024, $urandom_range(0, 2000), 1100);
    run_phase(16'($urandom), 11'($urandom_range(1, 16)), $urandom_range(0, 2000), 100);

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
design/trc_pkg.sv
design/trc_item_if.sv
design/trc_res_if.sv
design/trc_cfg_if.sv
design/trc_ram.sv
design/trc_ctrl.sv
design/trc_outq.sv
design/triggered_ring_capture_unit.sv
verif/triggered_ring_capture_unit_tb.sv
